[rtl/tks_pkg.sv]
// Shared types, constants and saturating helpers for the timestamp Kalman smoother.
// Used by tks_mul, tks_div and timestamp_kalman_smoother; depends on nothing.
package tks_pkg;

  localparam int CovFrac  = 48;
  localparam int GainIter = 128 + CovFrac;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [63:0]  s64_t;

  localparam wide_t S64Max = {64'b0, 1'b0, {63{1'b1}}};
  localparam wide_t S64Min = {{64{1'b1}}, 1'b1, 63'b0};
  localparam wide_t CovMin = {{64{1'b1}}, 1'b1, 62'b0, 1'b1};

  localparam logic [31:0] InitIntervalRst = 32'd143165577;
  localparam logic [47:0] ProcNoiseRst    = 48'd2814750;
  localparam logic [47:0] MeasNoiseRst    = 48'd140737488355;
  localparam s64_t        CovOne          = 64'sh0001_0000_0000_0000;

  localparam logic [1:0] CfgInitInterval = 2'd0;
  localparam logic [1:0] CfgProcNoise    = 2'd1;
  localparam logic [1:0] CfgMeasNoise    = 2'd2;

  function automatic wide_t sext(s64_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t zext(logic [63:0] v);
    return wide_t'({64'b0, v});
  endfunction

  function automatic s64_t clamp_s(wide_t a, wide_t lo);
    s64_t r;
    if (a < lo) begin
      r = lo[63:0];
    end else if (a > S64Max) begin
      r = S64Max[63:0];
    end else begin
      r = a[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] clamp_u(wide_t a);
    logic [63:0] r;
    if (a[127]) begin
      r = '0;
    end else if (a[127:64] != 64'b0) begin
      r = '1;
    end else begin
      r = a[63:0];
    end
    return r;
  endfunction

  // Round half up, then arithmetic shift right by the covariance fraction width.
  function automatic wide_t sar_round(wide_t a);
    wide_t t;
    t = a + (wide_t'(1) <<< (CovFrac - 1));
    return t >>> CovFrac;
  endfunction

endpackage

[rtl/tks_mul.sv]
// Iterative signed 64x64 multiplier, one 32x32 partial product per cycle.
// Depends on tks_pkg.
module tks_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tks_pkg::s64_t a_i,
  input  tks_pkg::s64_t b_i,
  output logic          done_o,
  output tks_pkg::wide_t prod_o
);
  import tks_pkg::*;

  logic [63:0]  am_q, bm_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [6:0]   shamt;

  assign a_half = cnt_q[0] ? am_q[63:32] : am_q[31:0];
  assign b_half = cnt_q[1] ? bm_q[63:32] : bm_q[31:0];
  assign pp     = a_half * b_half;
  assign shamt  = {({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}), 5'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[63] ? 64'(-a_i) : a_i;
      bm_q  <= b_i[63] ? 64'(-b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + ({64'b0, pp} << shamt);
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -wide_t'(acc_q) : wide_t'(acc_q);

endmodule

[rtl/tks_div.sv]
// Restoring divider for the gain: quotient of num * 2^48 / den, one bit per cycle,
// truncated toward zero and saturated to the symmetric 64-bit range. Depends on tks_pkg.
module tks_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tks_pkg::wide_t num_i,
  input  tks_pkg::wide_t den_i,
  output logic           done_o,
  output tks_pkg::s64_t  quo_o
);
  import tks_pkg::*;

  logic [127:0] n_q, d_q, rem_q;
  logic [63:0]  q_q;
  logic         ovf_q, neg_q, zero_q;
  logic [7:0]   cnt_q;
  logic         busy_q, done_q;
  logic [128:0] rem_sh, rem_sub;
  logic         ge;
  logic [63:0]  mag;

  assign rem_sh  = {rem_q, n_q[127]};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign ge      = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= start_i ? (den_i == '0) : (busy_q && (cnt_q == 8'(GainIter - 1)));
      if (start_i) begin
        cnt_q <= '0;
        if (den_i != '0) begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 8'd1;
        if (cnt_q == 8'(GainIter - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= num_i[127] ? 128'(-num_i) : num_i;
      d_q    <= den_i[127] ? 128'(-den_i) : den_i;
      neg_q  <= num_i[127] ^ den_i[127];
      zero_q <= (den_i == '0);
      rem_q  <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      n_q   <= {n_q[126:0], 1'b0};
      ovf_q <= ovf_q | q_q[63] | q_q[62];
      q_q   <= {q_q[62:0], ge};
      rem_q <= ge ? rem_sub[127:0] : rem_sh[127:0];
    end
  end

  assign mag    = (ovf_q || q_q[63]) ? S64Max[63:0] : q_q;
  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : (neg_q ? -s64_t'(mag) : s64_t'(mag));

endmodule

[rtl/timestamp_kalman_smoother.sv]
// Timestamp Kalman smoother: two-state constant-velocity filter over frame timestamps.
// The priming word primes the state directly; every later word goes through four gain
// divider runs and 22 multiplies (the divider runs skip iterating if P + R is singular).
// A new word is taken once the previous one is done.
// Reset (asynchronous, active low) restores the register defaults, clears the state and
// sets every covariance entry to one; no clearing pass is needed.
module timestamp_kalman_smoother
  import tks_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write port
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [47:0]   cfg_wdata_i,
  // Input stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [63:0]   s_axis_tdata_i,   // [63:0] observed_time
  // Output stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [127:0]  m_axis_tdata_o,   // [63:0] smoothed_time, [127:64] smoothed_interval
  output logic [1:0]    m_axis_tuser_o    // [0] frame_drop, [1] primed
);

  // Sequencer states.
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StPred    = 3'd1;
  localparam logic [2:0] StMeas    = 3'd2;
  localparam logic [2:0] StMulGo   = 3'd3;
  localparam logic [2:0] StMulWait = 3'd4;
  localparam logic [2:0] StDivGo   = 3'd5;
  localparam logic [2:0] StDivWait = 3'd6;
  localparam logic [2:0] StFin     = 3'd7;

  // Multiply-accumulate passes. Each pass forms the sum or difference of two products.
  localparam logic [3:0] StepDet  = 4'd0;
  localparam logic [3:0] StepNum0 = 4'd1;
  localparam logic [3:0] StepNum1 = 4'd2;
  localparam logic [3:0] StepNum2 = 4'd3;
  localparam logic [3:0] StepNum3 = 4'd4;
  localparam logic [3:0] StepTime = 4'd5;
  localparam logic [3:0] StepIntv = 4'd6;
  localparam logic [3:0] StepCov0 = 4'd7;
  localparam logic [3:0] StepCov1 = 4'd8;
  localparam logic [3:0] StepCov2 = 4'd9;
  localparam logic [3:0] StepCov3 = 4'd10;

  // Configuration registers.
  logic [31:0] init_iv_q;
  logic [47:0] qn_q, rn_q;

  // Filter state.
  logic [63:0] est_time_q, prev_q;
  s64_t        est_iv_q;
  s64_t        cov_q [4];
  logic        started_q;

  // Working registers for one word.
  logic [2:0]  state_q;
  logic [3:0]  step_q;
  logic        half_q;
  logic [1:0]  kidx_q;
  logic [63:0] obs_q, tp_q;
  s64_t        dt_q, s00_q, s11_q, y0_q, y1_q;
  s64_t        p_q [4];
  s64_t        k_q [4];
  wide_t       det_q, acc_q;
  wide_t       num_q [4];
  logic        drop_q, primed_q;

  // Output register.
  logic          m_valid_q;
  logic [127:0]  m_data_q;
  logic [1:0]    m_user_q;

  // Prediction, formed from the state registers.
  wide_t       qw, rw;
  s64_t        dt_w;
  logic [63:0] tp_w;
  s64_t        pp_w [4];

  assign qw   = wide_t'({80'b0, qn_q});
  assign rw   = wide_t'({80'b0, rn_q});
  assign dt_w = clamp_s(zext(obs_q) - zext(prev_q), S64Min);
  assign tp_w = clamp_u(zext(est_time_q) + sext(est_iv_q));

  always_comb begin
    pp_w[0] = clamp_s(sext(cov_q[0]) + sext(cov_q[1]) + sext(cov_q[2]) + sext(cov_q[3]) + qw,
                      CovMin);
    pp_w[1] = clamp_s(sext(cov_q[1]) + sext(cov_q[3]) + qw, CovMin);
    pp_w[2] = clamp_s(sext(cov_q[2]) + sext(cov_q[3]) + qw, CovMin);
    pp_w[3] = clamp_s(sext(cov_q[3]) + qw, CovMin);
  end

  // Measurement with the frame-drop rule: a gap above twice the predicted interval
  // zeroes both innovations.
  wide_t       gap_excess;
  logic        drop_w;
  logic [63:0] tp_m;
  s64_t        dt_m;

  assign gap_excess = sext(dt_q) - (sext(est_iv_q) + sext(est_iv_q));
  assign drop_w     = !gap_excess[127] && (gap_excess != '0);
  assign tp_m       = drop_w ? obs_q : tp_q;
  assign dt_m       = drop_w ? est_iv_q : dt_q;

  // Operand selection for the shared multiplier.
  s64_t  op_a, op_b;
  logic  minus;

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    minus = (step_q <= StepNum3);
    case (step_q)
      StepDet: begin
        op_a = half_q ? p_q[1] : s00_q;
        op_b = half_q ? p_q[2] : s11_q;
      end
      StepNum0: begin
        op_a = half_q ? p_q[1] : p_q[0];
        op_b = half_q ? p_q[2] : s11_q;
      end
      StepNum1: begin
        op_a = half_q ? p_q[0] : p_q[1];
        op_b = half_q ? p_q[1] : s00_q;
      end
      StepNum2: begin
        op_a = half_q ? p_q[3] : p_q[2];
        op_b = half_q ? p_q[2] : s11_q;
      end
      StepNum3: begin
        op_a = half_q ? p_q[2] : p_q[3];
        op_b = half_q ? p_q[1] : s00_q;
      end
      StepTime: begin
        op_a = half_q ? k_q[1] : k_q[0];
        op_b = half_q ? y1_q : y0_q;
      end
      StepIntv: begin
        op_a = half_q ? k_q[3] : k_q[2];
        op_b = half_q ? y1_q : y0_q;
      end
      StepCov0: begin
        op_a = half_q ? k_q[1] : k_q[0];
        op_b = half_q ? p_q[2] : p_q[0];
      end
      StepCov1: begin
        op_a = half_q ? k_q[1] : k_q[0];
        op_b = half_q ? p_q[3] : p_q[1];
      end
      StepCov2: begin
        op_a = half_q ? k_q[3] : k_q[2];
        op_b = half_q ? p_q[2] : p_q[0];
      end
      StepCov3: begin
        op_a = half_q ? k_q[3] : k_q[2];
        op_b = half_q ? p_q[3] : p_q[1];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  logic  mul_start, mul_done;
  wide_t prod;
  logic  div_start, div_done;
  s64_t  quo;
  wide_t pass_res, pass_sh;
  logic  in_fire, out_free;

  assign mul_start = (state_q == StMulGo);
  assign div_start = (state_q == StDivGo);
  assign pass_res  = minus ? (acc_q - prod) : (acc_q + prod);
  assign pass_sh   = sar_round(pass_res);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;

  tks_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tks_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q[kidx_q]),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_iv_q  <= InitIntervalRst;
      qn_q       <= ProcNoiseRst;
      rn_q       <= MeasNoiseRst;
      est_time_q <= '0;
      est_iv_q   <= '0;
      prev_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        cov_q[i] <= CovOne;
      end
      started_q  <= 1'b0;
      state_q    <= StIdle;
      step_q     <= StepDet;
      half_q     <= 1'b0;
      kidx_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgInitInterval: init_iv_q <= cfg_wdata_i[31:0];
          CfgProcNoise:    qn_q      <= cfg_wdata_i;
          CfgMeasNoise:    rn_q      <= cfg_wdata_i;
          default:         ;
        endcase
      end

      // A finished word loads the output register; otherwise a taken word frees it.
      if (state_q == StFin && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (!started_q) begin
              // The first word only primes the state.
              est_time_q <= s_axis_tdata_i;
              est_iv_q   <= s64_t'({32'b0, init_iv_q});
              prev_q     <= s_axis_tdata_i;
              started_q  <= 1'b1;
              state_q    <= StFin;
            end else begin
              state_q <= StPred;
            end
          end
        end
        StPred: begin
          prev_q  <= obs_q;
          state_q <= StMeas;
        end
        StMeas: begin
          step_q  <= StepDet;
          half_q  <= 1'b0;
          state_q <= StMulGo;
        end
        StMulGo: begin
          state_q <= StMulWait;
        end
        StMulWait: begin
          if (mul_done) begin
            if (!half_q) begin
              half_q  <= 1'b1;
              state_q <= StMulGo;
            end else begin
              half_q <= 1'b0;
              case (step_q)
                StepTime: est_time_q <= clamp_u(zext(tp_q) + pass_sh);
                StepIntv: est_iv_q   <= clamp_s(sext(est_iv_q) + pass_sh, S64Min);
                StepCov0, StepCov1, StepCov2, StepCov3: begin
                  cov_q[2'(step_q - StepCov0)] <=
                    clamp_s(sext(p_q[2'(step_q - StepCov0)]) - pass_sh, CovMin);
                end
                default: ;
              endcase
              if (step_q == StepNum3) begin
                kidx_q  <= '0;
                state_q <= StDivGo;
              end else if (step_q == StepCov3) begin
                state_q <= StFin;
              end else begin
                step_q  <= step_q + 4'd1;
                state_q <= StMulGo;
              end
            end
          end
        end
        StDivGo: begin
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_done) begin
            if (kidx_q == 2'd3) begin
              step_q  <= StepTime;
              state_q <= StMulGo;
            end else begin
              kidx_q  <= kidx_q + 2'd1;
              state_q <= StDivGo;
            end
          end
        end
        StFin: begin
          // The result waits here until the output register is free.
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      obs_q    <= s_axis_tdata_i;
      drop_q   <= 1'b0;
      primed_q <= started_q;
    end
    if (state_q == StPred) begin
      dt_q <= dt_w;
      tp_q <= tp_w;
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= pp_w[i];
      end
    end
    if (state_q == StMeas) begin
      drop_q <= drop_w;
      tp_q   <= tp_m;
      y0_q   <= clamp_s(zext(obs_q) - zext(tp_m), S64Min);
      y1_q   <= clamp_s(sext(dt_m) - sext(est_iv_q), S64Min);
      s00_q  <= clamp_s(sext(p_q[0]) + rw, CovMin);
      s11_q  <= clamp_s(sext(p_q[3]) + rw, CovMin);
    end
    if (state_q == StMulWait && mul_done) begin
      if (!half_q) begin
        acc_q <= prod;
      end else if (step_q == StepDet) begin
        det_q <= pass_res;
      end else if (step_q <= StepNum3) begin
        num_q[2'(step_q - StepNum0)] <= pass_res;
      end
    end
    if (state_q == StDivWait && div_done) begin
      k_q[kidx_q] <= quo;
    end
    if (state_q == StFin && out_free) begin
      m_data_q <= {est_iv_q, est_time_q};
      m_user_q <= {primed_q, drop_q};
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // Only one word is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != StIdle)
    else $error("word accepted without leaving idle");

  // The divider reports only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDivWait)
    else $error("divider finished outside its wait state");

  // The multiplier reports only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == StMulWait)
    else $error("multiplier finished outside its wait state");

  // A finished word reaches the output register once the slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free) |=> m_valid_q && state_q == StIdle)
    else $error("result not presented");

  // The priming word never carries a frame drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q[1]) |-> !m_user_q[0])
    else $error("drop flag on priming result");

endmodule

[test/tb_timestamp_kalman_smoother.sv]
// Self-checking testbench for timestamp_kalman_smoother: streams timestamp words through
// the block and compares every result with a bit-exact fixed-point predictor.
// Depends on tks_pkg (types, register indexes, reset values) and the top-level RTL only.
module tb_timestamp_kalman_smoother;
  timeunit 1ns;
  timeprecision 1ps;
  import tks_pkg::*;

  localparam wide_t MaxS64 = {64'b0, 1'b0, {63{1'b1}}};
  localparam wide_t MinS64 = {{64{1'b1}}, 1'b1, 63'b0};
  // Covariances saturate symmetrically, so their floor is one above the signed minimum.
  localparam wide_t MinCov = {{64{1'b1}}, 1'b1, 62'b0, 1'b1};
  localparam int unsigned CycleLimit = 3_000_000;

  typedef struct packed {
    logic [63:0] smoothed_time;
    s64_t        smoothed_interval;
    logic        frame_drop;
    logic        primed;
  } smooth_res_t;

  // Filter predictor plus the queue of smoothed words still owed by the block.
  class smoother_scoreboard;
    logic [31:0] init_interval;
    logic [47:0] proc_noise;
    logic [47:0] meas_noise;
    logic [63:0] est_time;
    s64_t        est_interval;
    logic [63:0] prev_time;
    s64_t        cov_p[4];
    bit          started;
    smooth_res_t owed[$];
    int unsigned errors;

    function new();
      init_interval = InitIntervalRst;
      proc_noise    = ProcNoiseRst;
      meas_noise    = MeasNoiseRst;
      est_time      = '0;
      est_interval  = '0;
      prev_time     = '0;
      foreach (cov_p[k]) cov_p[k] = CovOne;
      started       = 0;
      errors        = 0;
    endfunction

    function wide_t sx(s64_t v);
      return wide_t'(v);
    endfunction

    function wide_t zx(logic [63:0] v);
      return wide_t'({64'b0, v});
    endfunction

    function s64_t sat_s(wide_t a, wide_t floor_v);
      if (a < floor_v) return floor_v[63:0];
      if (a > MaxS64) return MaxS64[63:0];
      return a[63:0];
    endfunction

    function logic [63:0] sat_u(wide_t a);
      if (a[127]) return '0;
      if (a[127:64] != 0) return '1;
      return a[63:0];
    endfunction

    function s64_t sat_cov(wide_t a);
      return sat_s(a, MinCov);
    endfunction

    // Drop the covariance fraction bits with round-half-up.
    function wide_t rnd_shift(wide_t a);
      wide_t t;
      t = a + (wide_t'(1) <<< (CovFrac - 1));
      return t >>> CovFrac;
    endfunction

    function wide_t prod(s64_t a, s64_t b);
      return sx(a) * sx(b);
    endfunction

    // Kalman gain entry: num * 2^CovFrac / det, truncated toward zero and clamped.
    function s64_t gain_of(wide_t num, wide_t den);
      logic [127:0] nm, dm;
      logic [255:0] quo;
      s64_t m;
      if (den == 0) return '0;
      nm = num[127] ? -num : num;
      dm = den[127] ? -den : den;
      quo = ({128'b0, nm} << CovFrac) / {128'b0, dm};
      m = (quo > 256'h7FFF_FFFF_FFFF_FFFF) ? MaxS64[63:0] : s64_t'(quo[63:0]);
      return (num[127] ^ den[127]) ? -m : m;
    endfunction

    function void set_reg(logic [1:0] idx, logic [47:0] val);
      case (idx)
        CfgInitInterval: init_interval = val[31:0];
        CfgProcNoise:    proc_noise = val;
        CfgMeasNoise:    meas_noise = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Runs one filter step for an accepted timestamp and queues the expected word.
    function void note_input(logic [63:0] obs);
      smooth_res_t r;
      logic [63:0] tp;
      s64_t dt, ip, q, rn, p00, p01, p10, p11, s00, s11, y0, y1;
      s64_t k00, k01, k10, k11;
      wide_t d;
      bit drop;
      if (!started) begin
        est_time = obs;
        est_interval = s64_t'({32'b0, init_interval});
        prev_time = obs;
        started = 1;
        r = '{obs, est_interval, 1'b0, 1'b0};
        owed.push_back(r);
        return;
      end
      dt = sat_s(zx(obs) - zx(prev_time), MinS64);
      prev_time = obs;
      tp = sat_u(zx(est_time) + sx(est_interval));
      ip = est_interval;
      q  = s64_t'({16'b0, proc_noise});
      rn = s64_t'({16'b0, meas_noise});
      p00 = sat_cov(sx(cov_p[0]) + sx(cov_p[1]) + sx(cov_p[2]) + sx(cov_p[3]) + sx(q));
      p01 = sat_cov(sx(cov_p[1]) + sx(cov_p[3]) + sx(q));
      p10 = sat_cov(sx(cov_p[2]) + sx(cov_p[3]) + sx(q));
      p11 = sat_cov(sx(cov_p[3]) + sx(q));
      // A gap beyond twice the predicted interval counts as a dropped frame.
      d = sx(dt) - (sx(ip) + sx(ip));
      drop = !d[127] && (d != 0);
      if (drop) begin
        dt = ip;
        tp = obs;
      end
      y0 = sat_s(zx(obs) - zx(tp), MinS64);
      y1 = sat_s(sx(dt) - sx(ip), MinS64);
      s00 = sat_cov(sx(p00) + sx(rn));
      s11 = sat_cov(sx(p11) + sx(rn));
      d = prod(s00, s11) - prod(p01, p10);
      k00 = gain_of(prod(p00, s11) - prod(p01, p10), d);
      k01 = gain_of(prod(p01, s00) - prod(p00, p01), d);
      k10 = gain_of(prod(p10, s11) - prod(p11, p10), d);
      k11 = gain_of(prod(p11, s00) - prod(p10, p01), d);
      est_time = sat_u(zx(tp) + rnd_shift(prod(k00, y0) + prod(k01, y1)));
      est_interval = sat_s(sx(ip) + rnd_shift(prod(k10, y0) + prod(k11, y1)), MinS64);
      cov_p[0] = sat_cov(sx(p00) - rnd_shift(prod(k00, p00) + prod(k01, p10)));
      cov_p[1] = sat_cov(sx(p01) - rnd_shift(prod(k00, p01) + prod(k01, p11)));
      cov_p[2] = sat_cov(sx(p10) - rnd_shift(prod(k10, p00) + prod(k11, p10)));
      cov_p[3] = sat_cov(sx(p11) - rnd_shift(prod(k10, p01) + prod(k11, p11)));
      r = '{est_time, est_interval, drop, 1'b1};
      owed.push_back(r);
    endfunction

    function void check_result(logic [127:0] data, logic [1:0] user);
      smooth_res_t e;
      if (owed.size() == 0) begin
        $error("unexpected smoothed word: data %h user %b", data, user);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (data[63:0] !== e.smoothed_time) begin
        $error("smoothed_time: expected %h, got %h", e.smoothed_time, data[63:0]);
        errors++;
      end
      if (data[127:64] !== e.smoothed_interval) begin
        $error("smoothed_interval: expected %h, got %h", e.smoothed_interval, data[127:64]);
        errors++;
      end
      if (user[0] !== e.frame_drop) begin
        $error("frame_drop: expected %b, got %b", e.frame_drop, user[0]);
        errors++;
      end
      if (user[1] !== e.primed) begin
        $error("primed: expected %b, got %b", e.primed, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_index_i = '0;
  logic [47:0]   cfg_wdata_i = '0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [63:0]   s_axis_tdata_i = '0;    // [63:0] observed_time
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [127:0]  m_axis_tdata_o;         // [63:0] smoothed_time, [127:64] smoothed_interval
  logic [1:0]    m_axis_tuser_o;         // [0] frame_drop, [1] primed

  smoother_scoreboard sb = new();

  bit          quiet_mode = 0;   // no idling on either side when set
  bit          hold_req = 0;     // asks the receiver for one long hold-off
  logic [63:0] ts_now;           // timestamp of the last word sent
  logic [63:0] base_gap;         // nominal frame interval of the current phase
  int unsigned cycles = 0;

  timestamp_kalman_smoother u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver. Ready is driven at the rising edge and the handshake is judged at the
  // falling edge, where both sides are settled; the transfer then happens at the next
  // rising edge. A hold-off request stalls the output long enough for the block to
  // back up and drop its input ready while the sender keeps offering words.
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 4000;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (!quiet_mode && $urandom_range(7) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left = $urandom_range(14);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
      @(negedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Offers one timestamp word and waits for the rising edge that accepts it. Valid is
  // left high so a following word goes out back to back, unless a random idle drops it.
  task automatic send_word(logic [63:0] obs);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= obs;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
    end
    @(posedge clk_i);
    sb.note_input(obs);
    ts_now = obs;
    if (!quiet_mode && $urandom_range(5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every owed word has come back.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(logic [31:0] ii, logic [47:0] pn, logic [47:0] mn);
    drain();
    write_reg(CfgInitInterval, {16'b0, ii});
    write_reg(CfgProcNoise, pn);
    write_reg(CfgMeasNoise, mn);
  endtask

  // Mostly regular frame streams with jitter and dropped frames; the rest is noise
  // such as arbitrary timestamps and steps backward.
  task automatic random_words(int n);
    logic [63:0] jit, nxt;
    int unsigned pick;
    base_gap = ({32'b0, $urandom} >> $urandom_range(0, 28)) | 64'd1;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      jit = base_gap >> $urandom_range(3, 12);
      if (pick < 70) begin
        nxt = ($urandom_range(1)) ? ts_now + base_gap + jit : ts_now + base_gap - jit;
      end else if (pick < 82) begin
        nxt = ts_now + base_gap * $urandom_range(3, 6);
      end else if (pick < 90) begin
        nxt = ts_now - base_gap * $urandom_range(1, 3);
      end else begin
        nxt = {$urandom, $urandom};
      end
      send_word(nxt);
    end
  endtask

  initial begin : stim
    logic [63:0] t0;
    ts_now = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset register values: priming, a steady stream, a
    // dropped frame, a step backward, the extreme timestamps and saturating gaps.
    t0 = 64'h0000_0010_0000_0000;
    send_word(t0);
    for (int k = 1; k <= 4; k++) send_word(t0 + 64'(k) * 64'd143165577);
    send_word(ts_now + 64'd143165577 * 4);
    send_word(ts_now + 64'd143165577);
    send_word(ts_now - 64'd143165577);
    send_word(ts_now + 64'd143165570);
    send_word(64'h0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h7FFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 4; k++) send_word(ts_now + 64'd143165577);
    random_words(80);

    // Extremes of every register.
    set_regs(32'd1, 48'd0, 48'd0);
    random_words(90);
    set_regs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    random_words(40);

    // Long receiver hold-off while the sender keeps pushing.
    quiet_mode = 1;
    hold_req = 1;
    random_words(20);
    quiet_mode = 0;
    random_words(40);

    set_regs($urandom, 48'd0, 48'hFFFF_FFFF_FFFF);
    random_words(90);
    set_regs($urandom, 48'hFFFF_FFFF_FFFF, 48'd0);
    random_words(90);
    set_regs($urandom, 48'({$urandom, $urandom} >> 24), 48'({$urandom, $urandom} >> 20));
    random_words(90);
    set_regs($urandom | 32'd1, 48'd2814750, 48'd140737488355);

    // Last stretch runs without idling on either side.
    quiet_mode = 1;
    random_words(110);

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tks_pkg.sv
rtl/tks_mul.sv
rtl/tks_div.sv
rtl/timestamp_kalman_smoother.sv
test/tb_timestamp_kalman_smoother.sv
